>>> design/scan_elevator_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef SCAN_ELEVATOR_SCHEDULER_ASSERT_SVH
`define SCAN_ELEVATOR_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define SEV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed one cycle later");

`endif

>>> design/sev_pkg.sv
`timescale 1ns / 1ps
package sev_pkg;

   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int FLOOR_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int MAX_FLOORS = 1024;

   typedef enum logic [1:0] {
      CMD_ACTION = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      command_type        command;
      logic [FLOOR_W-1:0] floor;
   } req_payload_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] stop_floor;
      logic               going_up;
   } rsp_payload_type;

   typedef struct packed {
      logic             search_up;
      logic             use_car_bit;
      logic [BIT_W-1:0] car_bit;
   } scan_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] index;
   } scan_result_type;

endpackage

>>> design/sev_pending_store.sv
`timescale 1ns / 1ps
module sev_pending_store #(
   parameter int NWORDS = 32,
   parameter int ADDR_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [sev_pkg::WORD_W-1:0] rd_word,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [sev_pkg::WORD_W-1:0] wr_word
);
   import sev_pkg::*;

   logic [WORD_W-1:0] mem [NWORDS];
   logic [NWORDS-1:0] row_valid_ff;
   logic [NWORDS-1:0] row_valid_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   // A row never written since reset holds no pending floors.
   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> design/sev_word_scan.sv
`timescale 1ns / 1ps
module sev_word_scan (
   input  logic [sev_pkg::WORD_W-1:0] word,
   input  sev_pkg::scan_ctrl_type     ctrl,
   output sev_pkg::scan_result_type   result
);
   import sev_pkg::*;

   logic [WORD_W-1:0] masked;

   // In the car's own word only bits above the car (up) or at or below it (down) count.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         masked[i] = word[i] & (!ctrl.use_car_bit ||
                                (ctrl.search_up ? (BIT_W'(i) > ctrl.car_bit)
                                                : (BIT_W'(i) <= ctrl.car_bit)));
      end
   end

   always_comb begin
      result.found = |masked;
      result.index = '0;
      if (ctrl.search_up) begin
         for (int i = WORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
               result.index = BIT_W'(i);
            end
         end
      end else begin
         for (int i = 0; i < WORD_W; i++) begin
            if (masked[i]) begin
               result.index = BIT_W'(i);
            end
         end
      end
   end

endmodule

>>> design/scan_elevator_scheduler.sv
`timescale 1ns / 1ps
// SCAN elevator scheduler.
// Requests enter on req_valid/req_stall with req_payload (command, floor); each
// request returns one response on rsp_valid/rsp_stall carrying the car floor and
// direction after the request. Add marks a floor pending, cancel clears it, and
// action moves the car to the next pending floor in SCAN order.
// The pending floors live in a memory of 32-bit rows. A single word scanner
// examines one row per cycle: an action walks rows from the car's row toward the
// end of travel and, if nothing is found, turns and walks the other way.
// Add and cancel visit the scan state for their row, then the done state, which
// loads the response; action with nothing pending, an out-of-range floor or the
// unused code goes straight to done; action that searches stays in scan for each
// row visited, at most ceil(FLOORS/32) + 1 rows (33 for 1024 floors). One request
// is in work at a time; req_stall is high from acceptance until the response is
// loaded, so no new request is accepted before the last one's response is loaded.
// The response sits in an output register; while rsp_stall holds it, the next
// request may already be accepted and worked on, and it waits to load its result.
// Reset clears the car to floor 0 heading up, the pending count, and a valid bit
// per memory row, so no clearing pass is needed.
`include "scan_elevator_scheduler_assert.svh"
module scan_elevator_scheduler #(
   parameter int FLOORS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sev_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sev_pkg::rsp_payload_type rsp_payload
);
   import sev_pkg::*;

   localparam int NUM_FLOORS = (FLOORS < MAX_FLOORS) ? FLOORS : MAX_FLOORS;
   localparam int NWORDS     = (NUM_FLOORS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);

   state_type            state_ff, state_in;
   command_type          cmd_ff, cmd_in;
   logic [FLOOR_W-1:0]   floor_ff, floor_in;
   logic [WADDR_W-1:0]   waddr_ff, waddr_in;
   logic                 second_ff, second_in;
   logic [FLOOR_W-1:0]   car_ff, car_in;
   logic                 heading_ff, heading_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 in_range;
   logic                 slot_free;
   logic                 at_end;
   logic [WADDR_W-1:0]   car_word;
   logic [WADDR_W-1:0]   req_word;
   logic [BIT_W-1:0]     floor_bit;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_word;
   logic [WORD_W-1:0]    rd_word;
   scan_ctrl_type        scan_ctrl;
   scan_result_type      scan_res;
   logic                 action_scan;
   logic                 serve_hit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = 32'(req_payload.floor) < FLOORS;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign car_word   = car_ff[WADDR_W+BIT_W-1:BIT_W];
   assign req_word   = req_payload.floor[WADDR_W+BIT_W-1:BIT_W];
   assign floor_bit  = floor_ff[BIT_W-1:0];
   assign at_end     = heading_ff ? (waddr_ff == LAST_WORD) : (waddr_ff == '0);

   assign scan_ctrl.search_up   = heading_ff;
   assign scan_ctrl.use_car_bit = (waddr_ff == car_word);
   assign scan_ctrl.car_bit     = car_ff[BIT_W-1:0];

   assign action_scan = (state_ff == ST_SCAN) && (cmd_ff == CMD_ACTION);
   assign serve_hit   = action_scan && scan_res.found;

   sev_pending_store #(
      .NWORDS (NWORDS),
      .ADDR_W (WADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (waddr_in),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (waddr_ff),
      .wr_word (wr_word)
   );

   sev_word_scan u_scan (
      .word   (rd_word),
      .ctrl   (scan_ctrl),
      .result (scan_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_payload.command == CMD_ACTION && count_ff != '0) ||
                   ((req_payload.command == CMD_ADD || req_payload.command == CMD_CANCEL)
                    && in_range)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (cmd_ff != CMD_ACTION || scan_res.found || (at_end && second_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      floor_in     = floor_ff;
      waddr_in     = waddr_ff;
      second_in    = second_ff;
      car_in       = car_ff;
      heading_in   = heading_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_word      = rd_word;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_payload.command;
               floor_in  = req_payload.floor;
               second_in = 1'b0;
               waddr_in  = (req_payload.command == CMD_ACTION) ? car_word : req_word;
            end
         end
         ST_SCAN: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (!rd_word[floor_bit]) begin
                     wr_en    = 1'b1;
                     wr_word  = rd_word | (WORD_W'(1) << floor_bit);
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               CMD_CANCEL: begin
                  if (rd_word[floor_bit]) begin
                     wr_en    = 1'b1;
                     wr_word  = rd_word & ~(WORD_W'(1) << floor_bit);
                     count_in = count_ff - COUNT_W'(1);
                  end
               end
               CMD_ACTION: begin
                  if (scan_res.found) begin
                     wr_en    = 1'b1;
                     wr_word  = rd_word & ~(WORD_W'(1) << scan_res.index);
                     count_in = count_ff - COUNT_W'(1);
                     car_in   = FLOOR_W'({waddr_ff, scan_res.index});
                  end else if (!at_end) begin
                     waddr_in = heading_ff ? waddr_ff + WADDR_W'(1)
                                           : waddr_ff - WADDR_W'(1);
                  end else if (!second_ff) begin
                     // Nothing left this way: turn around and restart at the car's row.
                     heading_in = !heading_ff;
                     second_in  = 1'b1;
                     waddr_in   = car_word;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.stop_floor = car_ff;
               rsp_data_in.going_up   = heading_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         car_ff       <= '0;
         heading_ff   <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         car_ff       <= car_in;
         heading_ff   <= heading_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      floor_ff    <= floor_in;
      waddr_ff    <= waddr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `SEV_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= NUM_FLOORS)
   `SEV_ASSERT_SAME(a_car_in_range, clock, reset, 1'b1, 32'(car_ff) < NUM_FLOORS)
   `SEV_ASSERT_SAME(a_search_hits, clock, reset, action_scan && second_ff && at_end, scan_res.found)
   `SEV_ASSERT_NEXT(a_serve_count, clock, reset, serve_hit, count_ff == $past(count_ff) - COUNT_W'(1))

endmodule

>>> bench/scan_elevator_scheduler_test.sv
`timescale 1ns / 1ps
module scan_elevator_scheduler_test;
   import sev_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int TAIL_CYCLES   = 40;
   localparam int ITEMS_PER_RUN = 440;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   scan_elevator_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   req_payload_type     pending_requests[$];
   rsp_payload_type     expected_stops[$];
   rsp_payload_type     oldest_stop;
   int                  sender_gap_pct = 0;
   int                  receiver_stall_pct = 0;
   int                  error_count = 0;
   int                  quiet_cycles = 0;
   int                  response_count = 0;
   int                  recent_floors[$];

   // Shadow of the scheduler state.
   logic [MAX_FLOORS-1:0] waiting_floors = '0;
   int                    waiting_total = 0;
   logic [FLOOR_W-1:0]    car_at = '0;
   logic                  car_up = 1'b1;

   // Coverage tallies for the summary.
   int served_count = 0;
   int turn_count = 0;
   int idle_action_count = 0;
   int peak_waiting = 0;
   int command_tally[4] = '{0, 0, 0, 0};

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   function automatic int lowest_above();
      int f;
      for (f = int'(car_at) + 1; f < MAX_FLOORS; f++) begin
         if (waiting_floors[f]) return f;
      end
      return -1;
   endfunction

   function automatic int highest_at_or_below();
      int f;
      for (f = int'(car_at); f >= 0; f--) begin
         if (waiting_floors[f]) return f;
      end
      return -1;
   endfunction

   // Applies one request to the shadow state and returns the response it should produce.
   function automatic rsp_payload_type predict_stop(input req_payload_type r);
      rsp_payload_type res;
      int              hit;
      hit = -1;
      command_tally[r.command]++;
      case (r.command)
         CMD_ACTION: begin
            if (waiting_total == 0) begin
               idle_action_count++;
            end else begin
               if (car_up) begin
                  hit = lowest_above();
                  if (hit < 0) begin
                     car_up = 1'b0;
                     turn_count++;
                     hit = highest_at_or_below();
                  end
               end else begin
                  hit = highest_at_or_below();
                  if (hit < 0) begin
                     car_up = 1'b1;
                     turn_count++;
                     hit = lowest_above();
                  end
               end
               if (hit >= 0) begin
                  waiting_floors[hit] = 1'b0;
                  waiting_total--;
                  car_at = hit[FLOOR_W-1:0];
                  served_count++;
               end
            end
         end
         CMD_ADD: begin
            if (!waiting_floors[r.floor]) begin
               waiting_floors[r.floor] = 1'b1;
               waiting_total++;
               if (waiting_total > peak_waiting) peak_waiting = waiting_total;
            end
         end
         CMD_CANCEL: begin
            if (waiting_floors[r.floor]) begin
               waiting_floors[r.floor] = 1'b0;
               waiting_total--;
            end
         end
         default: ;
      endcase
      res.stop_floor = car_at;
      res.going_up = car_up;
      return res;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_stops.push_back(predict_stop(req_payload));
         if (pending_requests.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall generator.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (expected_stops.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected: floor %0d up %0b",
                                      rsp_payload.stop_floor, rsp_payload.going_up));
         end else begin
            oldest_stop = expected_stops.pop_front();
            if (rsp_payload.stop_floor !== oldest_stop.stop_floor)
               report_mismatch($sformatf("response %0d stop_floor %0d, expected %0d",
                                         response_count, rsp_payload.stop_floor,
                                         oldest_stop.stop_floor));
            if (rsp_payload.going_up !== oldest_stop.going_up)
               report_mismatch($sformatf("response %0d going_up %0b, expected %0b",
                                         response_count, rsp_payload.going_up,
                                         oldest_stop.going_up));
         end
      end
   end

   // Progress watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles, giving up", $time, QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(input command_type cmd, input logic [FLOOR_W-1:0] fl);
      req_payload_type r;
      r.command = cmd;
      r.floor = fl;
      pending_requests.push_back(r);
      if (cmd == CMD_ADD) begin
         recent_floors.push_back(int'(fl));
         if (recent_floors.size() > 64) void'(recent_floors.pop_front());
      end
   endtask

   function automatic logic [FLOOR_W-1:0] pick_cancel_floor();
      if (recent_floors.size() > 0 && $urandom_range(3) != 0)
         return FLOOR_W'(recent_floors[$urandom_range(recent_floors.size() - 1)]);
      return FLOOR_W'($urandom_range(MAX_FLOORS - 1));
   endfunction

   // Mostly add-then-serve sweeps with random floors, mixed with loose traffic.
   task automatic queue_random_traffic(input int count);
      int                 made;
      int                 kind;
      int                 burst;
      int                 i;
      int                 roll;
      logic [FLOOR_W-1:0] base;
      logic [FLOOR_W-1:0] fl;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(9);
         if (kind <= 4) begin
            burst = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
            base = FLOOR_W'($urandom_range(MAX_FLOORS - 1));
            for (i = 0; i < burst; i++) begin
               if ($urandom_range(1)) fl = FLOOR_W'($urandom_range(MAX_FLOORS - 1));
               else fl = base + FLOOR_W'($urandom_range(15));
               queue_request(CMD_ADD, fl);
               if ($urandom_range(7) == 0) begin
                  queue_request(CMD_ACTION, '0);
                  made++;
               end
            end
            if ($urandom_range(3) == 0) begin
               queue_request(CMD_CANCEL, pick_cancel_floor());
               made++;
            end
            for (i = 0; i < burst + $urandom_range(2); i++) begin
               queue_request(CMD_ACTION, FLOOR_W'($urandom_range(MAX_FLOORS - 1)));
            end
            made += 2 * burst;
         end else if (kind <= 8) begin
            roll = $urandom_range(99);
            if (roll < 35) queue_request(CMD_ACTION, FLOOR_W'($urandom_range(MAX_FLOORS - 1)));
            else if (roll < 75) queue_request(CMD_ADD, FLOOR_W'($urandom_range(MAX_FLOORS - 1)));
            else if (roll < 95) queue_request(CMD_CANCEL, pick_cancel_floor());
            else queue_request(CMD_NOP, FLOOR_W'($urandom_range(MAX_FLOORS - 1)));
            if (roll < 95) made++;
         end else begin
            burst = $urandom_range(1, 6);
            for (i = 0; i < burst; i++) queue_request(CMD_ACTION, '0);
            made += burst;
         end
      end
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_stops.size() != 0);
   endtask

   initial begin
      int phase;

      // Directed corners: empty actions, car-floor requests, both ends, turns.
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ADD, 10'd0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ADD, 10'd1023);
      queue_request(CMD_ADD, 10'd1023);
      queue_request(CMD_ADD, 10'd512);
      queue_request(CMD_CANCEL, 10'd512);
      queue_request(CMD_CANCEL, 10'd700);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ADD, 10'd5);
      queue_request(CMD_ADD, 10'd682);
      queue_request(CMD_ADD, 10'd341);
      queue_request(CMD_ADD, 10'd1023);
      queue_request(CMD_ACTION, 10'd1023);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_NOP, 10'd1023);
      queue_request(CMD_ADD, 10'd0);
      queue_request(CMD_ADD, 10'd1023);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_ACTION, '0);
      queue_request(CMD_NOP, 10'd0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_until_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 59; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 59; end
            default: begin sender_gap_pct = 34; receiver_stall_pct = 34; end
         endcase
         queue_random_traffic(ITEMS_PER_RUN);
         wait_until_drained();
      end

      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_stops.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_stops.size()));

      $display("Ran %0d requests: %0d actions, %0d adds, %0d cancels, %0d unused code.",
               response_count, command_tally[CMD_ACTION], command_tally[CMD_ADD],
               command_tally[CMD_CANCEL], command_tally[CMD_NOP]);
      $display("Car served %0d floors, turned %0d times, idled on %0d actions, peak %0d waiting.",
               served_count, turn_count, idle_action_count, peak_waiting);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/sev_pkg.sv
design/sev_pending_store.sv
design/sev_word_scan.sv
design/scan_elevator_scheduler.sv
bench/scan_elevator_scheduler_test.sv
